@@ design/quadrature_encoder_speed_position_defines.svh @@
// Assertion macros for the quadrature encoder speed and position block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef QUADRATURE_ENCODER_SPEED_POSITION_DEFINES_SVH
`define QUADRATURE_ENCODER_SPEED_POSITION_DEFINES_SVH
`ifndef NO_ASSERTIONS
// check that a holds implies b holds in the same cycle
`define QESP_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication check failed");
// check that a holds implies b holds in the next cycle
`define QESP_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define QESP_ASSERT_IMP(label, clk, rst_n, a, b)
`define QESP_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ design/qesp_pkg.sv @@
// Shared types and constants for the quadrature encoder speed and position block.
// Depends on nothing; used by every module of the block.
package qesp_pkg;

	localparam int EDGE_STEP_DEF = 4;
	localparam int MAX_EDGES_DEF = 32764;

	localparam int DIV_W = 35;
	localparam int DSR_W = 32;

	localparam logic [18:0] POS_SCALE = 19'd411775;
	localparam logic [31:0] GAP_FIRST = 32'h00FF_FFFF;
	localparam logic [31:0] TPE_FIRST = 32'h7FFF_FFFF;
	localparam logic [31:0] SPEED_SAT = 32'h7FFF_FFFF;

	// configuration register indexes
	localparam logic [2:0] REG_STRIPES = 3'd0;
	localparam logic [2:0] REG_SPEEDK  = 3'd1;
	localparam logic [2:0] REG_SLOW    = 3'd2;
	localparam logic [2:0] REG_FAST    = 3'd3;
	localparam logic [2:0] REG_TIMEOUT = 3'd4;

	// input command codes
	localparam logic [1:0] CODE_EVENT = 2'd0;
	localparam logic [1:0] CODE_TICK  = 2'd1;
	localparam logic [1:0] CODE_SET   = 2'd2;

	typedef enum logic [1:0] {
		CMD_EVENT = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_SET   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]         command;
		logic               count_up;
		logic [31:0]        timestamp;
		logic signed [15:0] live_count;
		logic signed [31:0] set_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] count_out;
		logic signed [31:0] position;
		logic signed [31:0] speed;
		logic               speed_valid;
		logic [14:0]        edge_limit;
		logic               limit_changed;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t kind;
		in_item_t  item;
	} q_entry_t;

	typedef struct packed {
		logic [15:0] stripes;
		logic [30:0] speedk;
		logic [23:0] slow;
		logic [23:0] fast;
		logic [7:0]  timeout;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ design/qesp_front.sv @@
// Front end: accepts input beats, classifies the command, queues up to two entries.
// Depends on qesp_pkg.
module qesp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  qesp_pkg::in_item_t  in_data,
	input  logic                pop,
	output logic                avail,
	output qesp_pkg::q_entry_t  head
);
	import qesp_pkg::*;

	q_entry_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_kind_t  kind;
	logic       push;
	logic       take;

	// classify the command code
	always_comb begin
		case (in_data.command)
			CODE_EVENT: kind = CMD_EVENT;
			CODE_TICK:  kind = CMD_TICK;
			CODE_SET:   kind = CMD_SET;
			default:    kind = CMD_NONE;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign avail    = (cnt_q != 2'd0);
	assign take     = pop && avail;
	assign head     = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{kind: kind, item: in_data};
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (take) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(take);
		end
	end

endmodule

@@ design/qesp_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on qesp_pkg.
module qesp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  qesp_pkg::div_req_t  req,
	output qesp_pkg::div_rsp_t  rsp
);
	import qesp_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dvd_q;
	logic [DSR_W:0]   rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q[DSR_W-1:0], dvd_q[DIV_W-1]};
	assign ge     = (rem_sh >= {1'b0, dsr_q});

	// datapath: shift, compare, subtract
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

endmodule

@@ design/qesp_core.sv @@
// Back end: executes queued commands, runs the divider, holds the result register.
// Depends on qesp_pkg and qesp_div.
module qesp_core #(
	parameter int EDGE_STEP = qesp_pkg::EDGE_STEP_DEF,
	parameter int MAX_EDGES = qesp_pkg::MAX_EDGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qesp_pkg::cfg_t      cfg,
	input  logic                avail,
	input  qesp_pkg::q_entry_t  head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output qesp_pkg::out_item_t out_data
);
	import qesp_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_EXEC = 9'b000000010,
		ST_TPE  = 9'b000000100,
		ST_SCD  = 9'b000001000,
		ST_SPD  = 9'b000010000,
		ST_POS  = 9'b000100000,
		ST_KDIV = 9'b001000000,
		ST_MUL  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t      state_q;
	q_entry_t    ent_q;
	logic [31:0] acc_q;
	logic [31:0] prev_q;
	logic [31:0] gap_q;
	logic [31:0] tpe_q;
	logic [14:0] epe_q;
	logic        up_q;
	logic        seen_q;
	logic        first_q;
	logic        pv_q;
	logic [7:0]  tl_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic        chg_q;
	logic [18:0] k_q;
	logic [31:0] cnt_q;
	logic [31:0] prod_q;
	div_req_t    dreq_q;
	div_rsp_t    drsp;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        ev_up;
	logic [31:0] gap_new;
	logic        same_dir;
	logic        div_need;
	logic [15:0] epe16;
	logic [15:0] epe_shrink;
	logic [15:0] epe_grow;
	logic [14:0] epe_adapt;
	logic        pv_tick;
	logic [31:0] mul_full;

	qesp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq_q),
		.rsp    (drsp)
	);

	// event arithmetic and edge limit adaptation
	always_comb begin
		ev_up      = ent_q.item.count_up;
		same_dir   = (ev_up == up_q) && first_q;
		gap_new    = same_dir ? (ent_q.item.timestamp - prev_q) : gap_q;
		div_need   = same_dir && (gap_new[31:23] == 9'd0);
		epe16      = {1'b0, epe_q};
		epe_shrink = (epe16 < 16'(2 * EDGE_STEP)) ? 16'(EDGE_STEP) : (epe16 - 16'(EDGE_STEP));
		epe_grow   = ((epe16 + 16'(EDGE_STEP)) > 16'(MAX_EDGES)) ? 16'(MAX_EDGES)
			: (epe16 + 16'(EDGE_STEP));
		if (gap_new > {8'd0, cfg.slow}) begin
			epe_adapt = epe_shrink[14:0];
		end else if (gap_new < {8'd0, cfg.fast}) begin
			epe_adapt = epe_grow[14:0];
		end else begin
			epe_adapt = epe_q;
		end
		pv_tick  = (!seen_q && tl_q == 8'd1) ? 1'b0 : pv_q;
		mul_full = cnt_q * {13'd0, k_q};
	end

	assign pop = (state_q == ST_IDLE) && avail;

	// sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			prev_q      <= '0;
			gap_q       <= '0;
			tpe_q       <= '0;
			epe_q       <= 15'(EDGE_STEP);
			up_q        <= 1'b0;
			seen_q      <= 1'b0;
			first_q     <= 1'b0;
			pv_q        <= 1'b0;
			tl_q        <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			chg_q       <= 1'b0;
			dreq_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			dreq_q.start <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (avail) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					chg_q   <= 1'b0;
					state_q <= ST_POS;
					case (ent_q.kind)
						CMD_EVENT: begin
							acc_q  <= ev_up ? (acc_q + {17'd0, epe_q}) : (acc_q - {17'd0, epe_q});
							up_q   <= ev_up;
							seen_q <= 1'b1;
							first_q <= 1'b1;
							prev_q <= ent_q.item.timestamp;
							if (first_q) begin
								gap_q <= gap_new;
								pv_q  <= 1'b1;
								epe_q <= epe_adapt;
								chg_q <= (epe_adapt != epe_q);
								if (div_need) begin
									dreq_q <= '{start: 1'b1,
										dividend: {4'd0, gap_new[22:0], 8'd0},
										divisor: {17'd0, epe_q}};
									state_q <= ST_TPE;
								end
							end else begin
								pv_q  <= 1'b0;
								gap_q <= GAP_FIRST;
								tpe_q <= TPE_FIRST;
							end
						end
						CMD_TICK: begin
							if (seen_q) begin
								seen_q <= 1'b0;
								tl_q   <= cfg.timeout;
							end else if (tl_q != 8'd0) begin
								tl_q <= tl_q - 8'd1;
								if (tl_q == 8'd1) first_q <= 1'b0;
							end
							pv_q  <= pv_tick;
							neg_q <= !up_q;
							if (!pv_tick) begin
								mag_q <= '0;
							end else if (tpe_q != 32'd0 && cfg.stripes != 16'd0) begin
								dreq_q <= '{start: 1'b1, dividend: {4'd0, cfg.speedk},
									divisor: {16'd0, cfg.stripes}};
								state_q <= ST_SCD;
							end
						end
						CMD_SET: begin
							acc_q <= ent_q.item.set_value;
						end
						default: begin
						end
					endcase
				end
				ST_TPE: begin
					if (drsp.done) begin
						tpe_q   <= drsp.quot[31:0];
						state_q <= ST_POS;
					end
				end
				ST_SCD: begin
					if (drsp.done) begin
						dreq_q <= '{start: 1'b1, dividend: {1'b0, drsp.quot[30:0], 3'd0},
							divisor: tpe_q};
						state_q <= ST_SPD;
					end
				end
				ST_SPD: begin
					if (drsp.done) begin
						mag_q <= (drsp.quot[34:17] != 18'd0) ? SPEED_SAT
							: {1'b0, drsp.quot[16:0], 14'd0};
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					cnt_q <= acc_q + {{16{ent_q.item.live_count[15]}}, ent_q.item.live_count};
					if (cfg.stripes == 16'd0) begin
						prod_q  <= '0;
						state_q <= ST_OUT;
					end else begin
						dreq_q <= '{start: 1'b1, dividend: {16'd0, POS_SCALE},
							divisor: {16'd0, cfg.stripes}};
						state_q <= ST_KDIV;
					end
				end
				ST_KDIV: begin
					if (drsp.done) begin
						k_q     <= drsp.quot[18:0];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= mul_full;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the popped entry and the result beat
	always_ff @(posedge clk) begin
		if (pop) ent_q <= head;
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			out_q.count_out     <= cnt_q;
			out_q.position      <= {{2{prod_q[31]}}, prod_q[31:2]};
			out_q.speed         <= neg_q ? (32'd0 - mag_q) : mag_q;
			out_q.speed_valid   <= pv_q;
			out_q.edge_limit    <= epe_q;
			out_q.limit_changed <= chg_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ design/quadrature_encoder_speed_position.sv @@
// Channel   | Signals                                  | Beat taken when
// in        | in_valid, in_stall, in_data (in_item_t)  | in_valid && !in_stall
// out       | out_valid, out_stall, out_data           | out_valid && !out_stall
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid && cfg_ready
//
// Each item runs its divisions one after another on the shared serial divider: the
// position scale needs one unless stripes is zero, an event's ticks per edge one more,
// a tick's speed two more. A two-entry queue takes beats while the back end works; the
// output register holds one result under stall. Asynchronous reset clears the control
// state and loads the configuration defaults; queue and result data are not reset.
// Top level: config registers, front queue, back end. Depends on qesp_pkg,
// qesp_front, qesp_core and the defines header.
`include "quadrature_encoder_speed_position_defines.svh"
module quadrature_encoder_speed_position #(
	parameter int EDGE_STEP = qesp_pkg::EDGE_STEP_DEF,
	parameter int MAX_EDGES = qesp_pkg::MAX_EDGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  qesp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output qesp_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [30:0]         cfg_data
);
	import qesp_pkg::*;

	cfg_t     cfg_q;
	logic     pop;
	logic     avail;
	q_entry_t head;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stripes <= 16'd100;
			cfg_q.speedk  <= 31'd1608495438;
			cfg_q.slow    <= 24'd8000;
			cfg_q.fast    <= 24'd2666;
			cfg_q.timeout <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STRIPES: cfg_q.stripes <= cfg_data[15:0];
				REG_SPEEDK:  cfg_q.speedk  <= cfg_data;
				REG_SLOW:    cfg_q.slow    <= cfg_data[23:0];
				REG_FAST:    cfg_q.fast    <= cfg_data[23:0];
				REG_TIMEOUT: cfg_q.timeout <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	qesp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	qesp_core #(
		.EDGE_STEP (EDGE_STEP),
		.MAX_EDGES (MAX_EDGES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.avail     (avail),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// edge limit stays between the step and the ceiling
	`QESP_ASSERT_IMP(a_limit_range, clk, arst_n, out_valid,
		out_data.edge_limit >= 15'(EDGE_STEP) && out_data.edge_limit <= 15'(MAX_EDGES))
	// adaptation only happens with a valid period
	`QESP_ASSERT_IMP(a_change_valid, clk, arst_n, out_valid && out_data.limit_changed,
		out_data.speed_valid)

endmodule
